[sv/swfr_pkg.sv]
// Shared types and constants of the frame receiver.
package swfr_pkg;

	localparam int          BUFFER_DEPTH_DEF = 32;
	localparam logic [7:0]  WIN_LIMIT_RST    = 8'd4;
	localparam logic [7:0]  ACK_TAG          = 8'h06;
	localparam logic [7:0]  EOF_MARK         = 8'hFF;

	localparam logic        KIND_ACK         = 1'b0;
	localparam logic        KIND_DATA        = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_ACK,
		ST_FL_RD,
		ST_FL_OUT
	} swfr_state_t;

endpackage

[sv/swfr_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module swfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[sv/sliding_window_frame_receiver_top.sv]
// Frame receiver with cumulative acknowledgement and in-order byte buffer.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------------
//  frame   | in        | in_valid / in_stall  | start_byte seq_num pre_data_byte
//          |           |                      | payload_byte post_data_byte frame_sum
//  result  | out       | out_valid/out_stall  | item_kind ack_seq ack_window ack_sum
//          |           |                      | out_byte run_last
//  config  | in        | cfg_wr_en            | cfg_wr_data (window_limit)
//
// Ignored frames pass through capture and evaluate only; an acked frame also passes the ack state.
// Each buffered byte delivered takes a RAM read state, then an output load state.
// The buffer RAM is written in evaluate and read only during a flush, so the
// sequencer keeps those accesses apart. Reset clears control state; RAM is
// not cleared. Output stall holds the sequencer in the ack or byte state.
module sliding_window_frame_receiver_top
	import swfr_pkg::*;
#(
	parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  start_byte,
	input  logic [31:0] seq_num,
	input  logic [7:0]  pre_data_byte,
	input  logic [7:0]  payload_byte,
	input  logic [7:0]  post_data_byte,
	input  logic [7:0]  frame_sum,

	output logic        out_valid,
	input  logic        out_stall,
	output logic        item_kind,
	output logic [31:0] ack_seq,
	output logic [7:0]  ack_window,
	output logic [7:0]  ack_sum,
	output logic [7:0]  out_byte,
	output logic        run_last,

	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data
);

	localparam int FILL_W = $clog2(BUFFER_DEPTH + 1);
	localparam int ADDR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
	localparam logic [FILL_W-1:0] DEPTH_F = FILL_W'(BUFFER_DEPTH);

	swfr_state_t state_q, state_d;

	logic [7:0]        lim_q;
	logic [31:0]       exp_q;
	logic [FILL_W-1:0] fill_q;
	logic              finished_q;
	logic              end_q;
	logic [FILL_W-1:0] cnt_q;
	logic [FILL_W-1:0] idx_q;

	logic [7:0]  start_q, pre_q, data_q, post_q, fsum_q;
	logic [31:0] seq_q;

	logic [31:0] aseq_q;
	logic [7:0]  awin_q;

	logic        out_valid_q, kind_q, last_q;
	logic [31:0] oseq_q;
	logic [7:0]  owin_q, osum_q, obyte_q;

	// evaluate-stage decode
	logic [7:0]        chk;
	logic              good, is_end, in_order, store, full, acting;
	logic [FILL_W-1:0] fill_inc, fill_nxt, win_fill, free_slots;
	logic [7:0]        free8, win;
	logic [7:0]        asum;

	logic              out_free, out_load, ld_last;
	logic              ram_we, ram_re;
	logic [7:0]        ram_rdata;
	logic              idx_is_last;

	always_comb begin
		chk = start_q + seq_q[7:0] + seq_q[15:8] + seq_q[23:16] + seq_q[31:24]
			+ pre_q + data_q + post_q;
		good     = (chk == fsum_q);
		is_end   = good && (data_q == EOF_MARK);
		in_order = good && (seq_q == exp_q);
		store    = in_order && (fill_q < DEPTH_F);
		fill_inc = fill_q + FILL_W'(store);
		full     = (fill_inc >= DEPTH_F);
		fill_nxt = full ? '0 : fill_inc;
		acting   = !finished_q && !is_end && (start_q != 8'd0);
		win_fill   = is_end ? fill_q : fill_nxt;
		free_slots = DEPTH_F - win_fill;
		free8      = 8'(free_slots);
		win        = (lim_q < free8) ? lim_q : free8;
		asum = ACK_TAG + aseq_q[7:0] + aseq_q[15:8] + aseq_q[23:16] + aseq_q[31:24] + awin_q;
		idx_is_last = ((idx_q + FILL_W'(1)) == cnt_q);
		out_free = !out_valid_q || !out_stall;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (finished_q) begin
					state_d = ST_IDLE;
				end else if (is_end) begin
					state_d = ST_ACK;
				end else if (start_q == 8'd0) begin
					state_d = ST_IDLE;
				end else if (full) begin
					state_d = ST_FL_RD;
				end else begin
					state_d = ST_ACK;
				end
			end
			ST_ACK: begin
				if (out_free) begin
					state_d = (end_q && cnt_q != '0) ? ST_FL_RD : ST_IDLE;
				end
			end
			ST_FL_RD: begin
				state_d = ST_FL_OUT;
			end
			ST_FL_OUT: begin
				if (out_free) begin
					if (!idx_is_last) begin
						state_d = ST_FL_RD;
					end else begin
						state_d = end_q ? ST_IDLE : ST_ACK;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_stall = (state_q != ST_IDLE);
		ram_we   = (state_q == ST_EVAL) && acting && store;
		ram_re   = (state_q == ST_FL_RD);
		out_load = ((state_q == ST_ACK) || (state_q == ST_FL_OUT)) && out_free;
		case (state_q)
			ST_ACK:    ld_last = !end_q || (cnt_q == '0);
			ST_FL_OUT: ld_last = end_q && idx_is_last;
			default:   ld_last = 1'b0;
		endcase
	end

	swfr_ram #(
		.WIDTH(8),
		.DEPTH(BUFFER_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (fill_q[ADDR_W-1:0]),
		.wdata (data_q),
		.re    (ram_re),
		.raddr (idx_q[ADDR_W-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			lim_q       <= WIN_LIMIT_RST;
			exp_q       <= '0;
			fill_q      <= '0;
			finished_q  <= 1'b0;
			end_q       <= 1'b0;
			cnt_q       <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				lim_q <= cfg_wr_data;
			end
			if (state_q == ST_EVAL) begin
				idx_q <= '0;
				if (!finished_q && is_end) begin
					end_q      <= 1'b1;
					cnt_q      <= fill_q;
					fill_q     <= '0;
					finished_q <= 1'b1;
				end else if (acting) begin
					end_q  <= 1'b0;
					cnt_q  <= full ? DEPTH_F : '0;
					fill_q <= fill_nxt;
					if (in_order) begin
						exp_q <= seq_q + 32'd1;
					end
				end
			end
			if (state_q == ST_FL_OUT && out_free) begin
				idx_q <= idx_q + FILL_W'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			start_q <= start_byte;
			seq_q   <= seq_num;
			pre_q   <= pre_data_byte;
			data_q  <= payload_byte;
			post_q  <= post_data_byte;
			fsum_q  <= frame_sum;
		end
		if (state_q == ST_EVAL) begin
			aseq_q <= (is_end || in_order) ? seq_q + 32'd1 : exp_q;
			awin_q <= win;
		end
		if (out_load) begin
			last_q <= ld_last;
			if (state_q == ST_ACK) begin
				kind_q  <= KIND_ACK;
				oseq_q  <= aseq_q;
				owin_q  <= awin_q;
				osum_q  <= asum;
				obyte_q <= 8'd0;
			end else begin
				kind_q  <= KIND_DATA;
				oseq_q  <= '0;
				owin_q  <= 8'd0;
				osum_q  <= 8'd0;
				obyte_q <= ram_rdata;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign item_kind  = kind_q;
	assign ack_seq    = oseq_q;
	assign ack_window = owin_q;
	assign ack_sum    = osum_q;
	assign out_byte   = obyte_q;
	assign run_last   = last_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= DEPTH_F)
		else $error("fill count beyond buffer depth");

	a_finished_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		finished_q |=> finished_q)
		else $error("finished flag cleared without reset");

	a_no_write_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		finished_q |-> !ram_we)
		else $error("buffer written after end of transfer");

	a_flush_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FL_RD) |-> (idx_q < cnt_q))
		else $error("flush read past buffered count");

endmodule
